// ----- sv/bffc_pkg.sv -----
// ----------------------------------------------------------------------------
// bffc_pkg: shared types and constants of the frame checker
// Status codes, frame layout constants and the result word that the
// checking core hands to the output stage.
// ----------------------------------------------------------------------------
package bffc_pkg;

  // Width of one frame byte.
  localparam int unsigned ByteW = 8;

  // Bytes ahead of the payload: class, id and two length bytes.
  localparam logic [16:0] HeaderBytes = 17'd4;

  // Header plus the two check bytes.
  localparam logic [16:0] FrameOverhead = 17'd6;

  typedef enum logic [1:0] {
    StatusOk       = 2'd0,
    StatusMismatch = 2'd1,
    StatusTooLong  = 2'd2
  } status_e;

  // One result word from the checking core.
  typedef struct packed {
    logic               valid;
    status_e            status;
    logic [ByteW-1:0]   msg_class;
    logic [ByteW-1:0]   msg_id;
    logic [15:0]        payload_length;
  } result_t;

endpackage

// ----- sv/bffc_core.sv -----
// ----------------------------------------------------------------------------
// bffc_core: frame state and Fletcher sums
// Tracks the position within a frame, keeps the header fields and both
// running sums, and decides on each byte whether a result is due.
// ----------------------------------------------------------------------------
module bffc_core #(
  parameter int MAX_FRAME_BYTES = 1024
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic [bffc_pkg::ByteW-1:0]  data_byte_i,
  input  logic                        frame_start_i,
  output bffc_pkg::result_t           result_o
);

  localparam logic [16:0] MaxFrame = 17'(MAX_FRAME_BYTES);

  logic [16:0]               pos_q, pos_d;
  logic                      in_frame_q, in_frame_d;
  logic [15:0]               len_q, len_d;
  logic [bffc_pkg::ByteW-1:0] sum_a_q, sum_a_d;
  logic [bffc_pkg::ByteW-1:0] sum_b_q, sum_b_d;
  logic [bffc_pkg::ByteW-1:0] class_q, class_d;
  logic [bffc_pkg::ByteW-1:0] id_q, id_d;
  logic [bffc_pkg::ByteW-1:0] chk_a_q, chk_a_d;

  logic [bffc_pkg::ByteW-1:0] acc_a;
  logic [bffc_pkg::ByteW-1:0] acc_b;
  logic [15:0]                len_full;
  logic [16:0]                payload_end;

  // One Fletcher step on the incoming byte; sums restart on a frame start.
  always_comb begin
    acc_a = (frame_start_i ? '0 : sum_a_q) + data_byte_i;
    acc_b = (frame_start_i ? '0 : sum_b_q) + acc_a;
  end

  assign len_full    = {data_byte_i, len_q[7:0]};
  assign payload_end = bffc_pkg::HeaderBytes + {1'b0, len_q};

  // Next state and result for the byte on the inputs.
  always_comb begin
    pos_d      = pos_q;
    in_frame_d = in_frame_q;
    len_d      = len_q;
    sum_a_d    = sum_a_q;
    sum_b_d    = sum_b_q;
    class_d    = class_q;
    id_d       = id_q;
    chk_a_d    = chk_a_q;

    result_o                = '0;
    result_o.msg_class      = class_q;
    result_o.msg_id         = id_q;
    result_o.payload_length = len_q;

    if (frame_start_i) begin
      class_d    = data_byte_i;
      id_d       = '0;
      len_d      = '0;
      chk_a_d    = '0;
      sum_a_d    = acc_a;
      sum_b_d    = acc_b;
      pos_d      = 17'd1;
      in_frame_d = 1'b1;
    end else if (in_frame_q) begin
      if (pos_q == 17'd1) begin
        id_d    = data_byte_i;
        sum_a_d = acc_a;
        sum_b_d = acc_b;
        pos_d   = 17'd2;
      end else if (pos_q == 17'd2) begin
        len_d   = {8'd0, data_byte_i};
        sum_a_d = acc_a;
        sum_b_d = acc_b;
        pos_d   = 17'd3;
      end else if (pos_q == 17'd3) begin
        len_d   = len_full;
        sum_a_d = acc_a;
        sum_b_d = acc_b;
        pos_d   = bffc_pkg::HeaderBytes;
        // Declared length does not fit the frame limit.
        if (({1'b0, len_full} + bffc_pkg::FrameOverhead) > MaxFrame) begin
          in_frame_d              = 1'b0;
          result_o.valid          = 1'b1;
          result_o.status         = bffc_pkg::StatusTooLong;
          result_o.payload_length = len_full;
        end
      end else if (pos_q < payload_end) begin
        sum_a_d = acc_a;
        sum_b_d = acc_b;
        pos_d   = pos_q + 17'd1;
      end else if (pos_q == payload_end) begin
        chk_a_d = data_byte_i;
        pos_d   = pos_q + 17'd1;
      end else begin
        // Second check byte closes the frame.
        in_frame_d     = 1'b0;
        result_o.valid = 1'b1;
        result_o.status = (chk_a_q == sum_a_q && data_byte_i == sum_b_q) ?
                          bffc_pkg::StatusOk : bffc_pkg::StatusMismatch;
      end
    end
  end

  // State registers, updated only when a word is processed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      in_frame_q <= 1'b0;
      len_q      <= '0;
      sum_a_q    <= '0;
      sum_b_q    <= '0;
      class_q    <= '0;
      id_q       <= '0;
      chk_a_q    <= '0;
    end else if (en_i) begin
      pos_q      <= pos_d;
      in_frame_q <= in_frame_d;
      len_q      <= len_d;
      sum_a_q    <= sum_a_d;
      sum_b_q    <= sum_b_d;
      class_q    <= class_d;
      id_q       <= id_d;
      chk_a_q    <= chk_a_d;
    end
  end

endmodule

// ----- sv/binary_frame_fletcher_check.sv -----
// ----------------------------------------------------------------------------
// binary_frame_fletcher_check: byte-wise check of binary navigation frames
// Runs the two 8-bit Fletcher sums over each frame and reports header and
// check status at most once per frame.
// ----------------------------------------------------------------------------
// Bytes enter one word per cycle while the input is not stalled, with the sync
// bytes already stripped; the class byte is flagged by frame_start_i. A word
// passes through an input register and then through the checking core into
// the output register; a new byte is taken in every cycle unless the input
// stalls. The core does its single-byte Fletcher update and position compare
// combinationally. Input stalls only while the output register holds
// a result that the receiver is stalling. A too-long declared length is
// reported on the second length byte; a frame restart mid-frame gives no result.
module binary_frame_fletcher_check #(
  parameter int MAX_FRAME_BYTES = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        frame_start_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [7:0]  msg_class_o,
  output logic [7:0]  msg_id_o,
  output logic [15:0] payload_length_o
);

  logic              in_valid_q;
  logic [7:0]        byte_q;
  logic              start_q;
  logic              advance;
  logic              process;
  bffc_pkg::result_t core_res;
  bffc_pkg::result_t out_d;
  bffc_pkg::result_t out_q;

  // The output register can take a new word when empty or being drained.
  assign advance    = !out_q.valid || !out_stall_i;
  assign process    = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      byte_q  <= data_byte_i;
      start_q <= frame_start_i;
    end
  end

  bffc_core #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (process),
    .data_byte_i  (byte_q),
    .frame_start_i(start_q),
    .result_o     (core_res)
  );

  // A result is only valid when a word was actually processed.
  always_comb begin
    out_d       = core_res;
    out_d.valid = process && core_res.valid;
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_q <= '0;
    end else if (advance) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o      = out_q.valid;
  assign status_o         = out_q.status;
  assign msg_class_o      = out_q.msg_class;
  assign msg_id_o         = out_q.msg_id;
  assign payload_length_o = out_q.payload_length;

  // The input side only stalls behind a held result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held result");

  // A delivered status is always one of the defined codes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == bffc_pkg::StatusOk ||
                     status_o == bffc_pkg::StatusMismatch ||
                     status_o == bffc_pkg::StatusTooLong))
    else $error("undefined status code on output");

  // A length error only reports a length beyond the frame limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == bffc_pkg::StatusTooLong) |->
      (({1'b0, payload_length_o} + bffc_pkg::FrameOverhead) > 17'(MAX_FRAME_BYTES)))
    else $error("length error reported for a length that fits");

endmodule
